// File: sv/rth_pkg.sv
// Shared widths, types and register codes of the ray/triangle hit test.
package rth_pkg;

    // Coordinate width of the vertices and the ray registers (signed Q16.16 at 32).
    localparam int COORD_WIDTH = 32;

    // Edge and offset vectors are differences of two coordinates.
    localparam int DW = COORD_WIDTH + 1;
    // Full product of two difference values.
    localparam int PW = 2 * DW;
    // Cross product component: difference of two full products.
    localparam int XW = PW + 1;
    // Split of a cross component for the dot products: unsigned low part, signed high part.
    localparam int LW = DW;
    localparam int HW = XW - LW;
    // Partial products of the split multiply.
    localparam int LPW = LW + 1 + DW;
    localparam int HPW = HW + DW;
    // One recombined dot term, the sum of three terms, and the compare width.
    localparam int TW = XW + DW;
    localparam int SW = TW + 2;
    localparam int KW = SW + 2;

    // Pipeline depth, one enable per register stage.
    localparam int NSTAGE = 8;

    // Configuration port.
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DW-1:0]          t_diff;
    typedef logic signed [PW-1:0]          t_prod;
    typedef logic signed [XW-1:0]          t_cross;
    typedef logic signed [LPW-1:0]         t_lo_prod;
    typedef logic signed [HPW-1:0]         t_hi_prod;
    typedef logic signed [TW-1:0]          t_term;
    typedef logic signed [SW-1:0]          t_sum;
    typedef logic signed [KW-1:0]          t_cmp;
    typedef logic [NSTAGE-1:0]             t_stage_en;

    // Reset value of the direction z register: 1.0, kept modulo the coordinate width.
    localparam t_coord DIR_Z_RESET = t_coord'(65536);

endpackage

// File: sv/rth_cross.sv
// Two-stage cross product unit: six products, then three differences.
module rth_cross (
    input  logic           i_clk,
    input  logic [1:0]     i_en,
    input  rth_pkg::t_diff i_a [3],
    input  rth_pkg::t_diff i_b [3],
    output rth_pkg::t_cross o_c [3]
);

    rth_pkg::t_prod  r_prod [6];
    rth_pkg::t_prod  n_prod [6];
    rth_pkg::t_cross r_c [3];
    rth_pkg::t_cross n_c [3];

    // First stage: the six full-width products of the cross product.
    always_comb begin
        n_prod[0] = rth_pkg::t_prod'(i_a[1]) * rth_pkg::t_prod'(i_b[2]);
        n_prod[1] = rth_pkg::t_prod'(i_a[2]) * rth_pkg::t_prod'(i_b[1]);
        n_prod[2] = rth_pkg::t_prod'(i_a[2]) * rth_pkg::t_prod'(i_b[0]);
        n_prod[3] = rth_pkg::t_prod'(i_a[0]) * rth_pkg::t_prod'(i_b[2]);
        n_prod[4] = rth_pkg::t_prod'(i_a[0]) * rth_pkg::t_prod'(i_b[1]);
        n_prod[5] = rth_pkg::t_prod'(i_a[1]) * rth_pkg::t_prod'(i_b[0]);
    end

    // Second stage: one difference per component.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_c[i] = rth_pkg::t_cross'(r_prod[2*i]) - rth_pkg::t_cross'(r_prod[2*i+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod <= n_prod;
        end
        if (i_en[1]) begin
            r_c <= n_c;
        end
    end

    assign o_c = r_c;

endmodule

// File: sv/rth_dot.sv
// Three-stage dot product unit with the wide operand split into two partial products.
module rth_dot (
    input  logic            i_clk,
    input  logic [2:0]      i_en,
    input  rth_pkg::t_cross i_a [3],
    input  rth_pkg::t_diff  i_b [3],
    output rth_pkg::t_sum   o_dot
);

    rth_pkg::t_lo_prod r_lo [3];
    rth_pkg::t_lo_prod n_lo [3];
    rth_pkg::t_hi_prod r_hi [3];
    rth_pkg::t_hi_prod n_hi [3];
    rth_pkg::t_term    r_term [3];
    rth_pkg::t_term    n_term [3];
    rth_pkg::t_sum     r_sum;
    rth_pkg::t_sum     n_sum;

    // First stage: low half (unsigned) and high half (signed) times the narrow operand.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_lo[i] = rth_pkg::t_lo_prod'($signed({1'b0, i_a[i][rth_pkg::LW-1:0]}))
                    * rth_pkg::t_lo_prod'(i_b[i]);
            n_hi[i] = rth_pkg::t_hi_prod'($signed(i_a[i][rth_pkg::XW-1:rth_pkg::LW]))
                    * rth_pkg::t_hi_prod'(i_b[i]);
        end
    end

    // Second stage: recombine the halves into one exact product per component.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_term[i] = (rth_pkg::t_term'(r_hi[i]) <<< rth_pkg::LW)
                      + rth_pkg::t_term'(r_lo[i]);
        end
    end

    // Third stage: sum of the three components.
    assign n_sum = rth_pkg::t_sum'(r_term[0]) + rth_pkg::t_sum'(r_term[1])
                 + rth_pkg::t_sum'(r_term[2]);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (i_en[1]) begin
            r_term <= n_term;
        end
        if (i_en[2]) begin
            r_sum <= n_sum;
        end
    end

    assign o_dot = r_sum;

endmodule

// File: sv/rth_ctl.sv
// Pipeline control: per-stage valid bits and the ready chain that fills bubbles.
module rth_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_out_ready,
    output logic               o_in_ready,
    output rth_pkg::t_stage_en o_en,
    output logic               o_out_valid
);

    localparam int N = rth_pkg::NSTAGE;

    logic [N-1:0] r_valid;
    logic [N-1:0] n_valid;
    logic [N:0]   w_rdy;

    // A stage may load when it is empty or its content moves on.
    always_comb begin
        w_rdy[N] = i_out_ready;
        for (int k = N - 1; k >= 0; k--) begin
            w_rdy[k] = !r_valid[k] || w_rdy[k+1];
        end
    end

    assign o_en = w_rdy[N-1:0];

    // Valid bits move with the data of each loading stage.
    always_comb begin
        for (int k = 0; k < N; k++) begin
            if (w_rdy[k]) begin
                n_valid[k] = (k == 0) ? i_valid : r_valid[(k == 0) ? 0 : k - 1];
            end else begin
                n_valid[k] = r_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_valid[N-1];

    // Items in flight change only by the items taken in and handed out.
    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ($countones(r_valid) == $countones($past(r_valid))
            + int'($past(i_valid && o_in_ready))
            - int'($past(o_out_valid && i_out_ready))))
        else $error("pipeline item count mismatch");

    // The input side is refused only when every stage holds an item.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_valid))
        else $error("input refused with a free stage");

    // With the receiver taking items, the pipeline always moves.
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input refused while the output drains");

endmodule

// File: sv/ray_triangle_hit_test.sv
// Top level of the ray/triangle line hit test pipeline.
//
// Usage: the ray origin and direction are written through the configuration
// port (i_cfg_wr_en, i_cfg_index, i_cfg_data) while no item is in flight.
// Indexes 0..2 set the origin x/y/z, 3..5 the direction x/y/z; other
// indexes are ignored. Triangles then enter on the input channel
// (i_valid/o_ready), one per item, with three vertices in signed Q16.16.
// Each item yields one item on the output channel (o_valid/i_ready) whose
// o_hit is 1 when the line of the ray crosses the triangle, edges included.
// One item is accepted every cycle while the receiver takes results, and
// the eight register stages are edges, cross products (2), split dot
// products (3), compare, result.
// When the receiver stalls, each stage holds its item and empty stages
// ahead of it still fill, so o_ready falls only once all eight hold items.
// Reset clears every stage, sets the origin to 0 and the direction to
// (0, 0, 1.0).
module ray_triangle_hit_test (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [rth_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  rth_pkg::t_coord                     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  rth_pkg::t_coord                     i_vertex_a_x,
    input  rth_pkg::t_coord                     i_vertex_a_y,
    input  rth_pkg::t_coord                     i_vertex_a_z,
    input  rth_pkg::t_coord                     i_vertex_b_x,
    input  rth_pkg::t_coord                     i_vertex_b_y,
    input  rth_pkg::t_coord                     i_vertex_b_z,
    input  rth_pkg::t_coord                     i_vertex_c_x,
    input  rth_pkg::t_coord                     i_vertex_c_y,
    input  rth_pkg::t_coord                     i_vertex_c_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_hit
);

    localparam int KW = rth_pkg::KW;

    rth_pkg::t_coord r_ray_origin_x;
    rth_pkg::t_coord r_ray_origin_y;
    rth_pkg::t_coord r_ray_origin_z;
    rth_pkg::t_coord r_ray_dir_x;
    rth_pkg::t_coord r_ray_dir_y;
    rth_pkg::t_coord r_ray_dir_z;

    rth_pkg::t_stage_en w_en;

    rth_pkg::t_diff w_dir [3];
    rth_pkg::t_diff n_e1 [3];
    rth_pkg::t_diff n_e2 [3];
    rth_pkg::t_diff n_t [3];
    rth_pkg::t_diff r_e1 [3];
    rth_pkg::t_diff r_e2 [3];
    rth_pkg::t_diff r_t [3];
    rth_pkg::t_diff r_e1_s2 [3];
    rth_pkg::t_diff r_t_s2 [3];
    rth_pkg::t_diff r_e1_s3 [3];
    rth_pkg::t_diff r_t_s3 [3];

    rth_pkg::t_cross w_p [3];
    rth_pkg::t_cross w_q [3];
    rth_pkg::t_sum   w_det;
    rth_pkg::t_sum   w_u;
    rth_pkg::t_sum   w_v;

    rth_pkg::t_cmp n_det_k;
    rth_pkg::t_cmp n_u_k;
    rth_pkg::t_cmp n_v_k;
    rth_pkg::t_cmp n_du;
    rth_pkg::t_cmp n_w;
    rth_pkg::t_cmp r_det_k;
    rth_pkg::t_cmp r_w;
    logic          r_det_neg;
    logic          r_det_zero;
    logic          r_u_ge;
    logic          r_u_le;
    logic          r_v_ge;
    logic          r_v_le;
    logic          r_du_ge;
    logic          r_du_le;

    rth_pkg::t_cmp n_dw;
    logic          w_dw_ge;
    logic          w_dw_le;
    logic          n_hit;
    logic          r_hit;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray_origin_x <= '0;
            r_ray_origin_y <= '0;
            r_ray_origin_z <= '0;
            r_ray_dir_x    <= '0;
            r_ray_dir_y    <= '0;
            r_ray_dir_z    <= rth_pkg::DIR_Z_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                rth_pkg::REG_ORIGIN_X: r_ray_origin_x <= i_cfg_data;
                rth_pkg::REG_ORIGIN_Y: r_ray_origin_y <= i_cfg_data;
                rth_pkg::REG_ORIGIN_Z: r_ray_origin_z <= i_cfg_data;
                rth_pkg::REG_DIR_X:    r_ray_dir_x    <= i_cfg_data;
                rth_pkg::REG_DIR_Y:    r_ray_dir_y    <= i_cfg_data;
                rth_pkg::REG_DIR_Z:    r_ray_dir_z    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Stage control.
    rth_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_ready (i_ready),
        .o_in_ready  (o_ready),
        .o_en        (w_en),
        .o_out_valid (o_valid)
    );

    // Stage 1: triangle edges and the origin offset.
    always_comb begin
        w_dir[0] = rth_pkg::t_diff'(r_ray_dir_x);
        w_dir[1] = rth_pkg::t_diff'(r_ray_dir_y);
        w_dir[2] = rth_pkg::t_diff'(r_ray_dir_z);
        n_e1[0]  = rth_pkg::t_diff'(i_vertex_b_x) - rth_pkg::t_diff'(i_vertex_a_x);
        n_e1[1]  = rth_pkg::t_diff'(i_vertex_b_y) - rth_pkg::t_diff'(i_vertex_a_y);
        n_e1[2]  = rth_pkg::t_diff'(i_vertex_b_z) - rth_pkg::t_diff'(i_vertex_a_z);
        n_e2[0]  = rth_pkg::t_diff'(i_vertex_c_x) - rth_pkg::t_diff'(i_vertex_a_x);
        n_e2[1]  = rth_pkg::t_diff'(i_vertex_c_y) - rth_pkg::t_diff'(i_vertex_a_y);
        n_e2[2]  = rth_pkg::t_diff'(i_vertex_c_z) - rth_pkg::t_diff'(i_vertex_a_z);
        n_t[0]   = rth_pkg::t_diff'(r_ray_origin_x) - rth_pkg::t_diff'(i_vertex_a_x);
        n_t[1]   = rth_pkg::t_diff'(r_ray_origin_y) - rth_pkg::t_diff'(i_vertex_a_y);
        n_t[2]   = rth_pkg::t_diff'(r_ray_origin_z) - rth_pkg::t_diff'(i_vertex_a_z);
    end

    // Edge and offset values, delayed alongside the cross product stages.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_e1 <= n_e1;
            r_e2 <= n_e2;
            r_t  <= n_t;
        end
        if (w_en[1]) begin
            r_e1_s2 <= r_e1;
            r_t_s2  <= r_t;
        end
        if (w_en[2]) begin
            r_e1_s3 <= r_e1_s2;
            r_t_s3  <= r_t_s2;
        end
    end

    // Stages 2 and 3: p = dir x e2 and q = t x e1.
    rth_cross u_cross_p (
        .i_clk (i_clk),
        .i_en  (w_en[2:1]),
        .i_a   (w_dir),
        .i_b   (r_e2),
        .o_c   (w_p)
    );

    rth_cross u_cross_q (
        .i_clk (i_clk),
        .i_en  (w_en[2:1]),
        .i_a   (r_t),
        .i_b   (r_e1),
        .o_c   (w_q)
    );

    // Stages 4 to 6: det = p.e1, u = p.t, v = q.dir.
    rth_dot u_dot_det (
        .i_clk (i_clk),
        .i_en  (w_en[5:3]),
        .i_a   (w_p),
        .i_b   (r_e1_s3),
        .o_dot (w_det)
    );

    rth_dot u_dot_u (
        .i_clk (i_clk),
        .i_en  (w_en[5:3]),
        .i_a   (w_p),
        .i_b   (r_t_s3),
        .o_dot (w_u)
    );

    rth_dot u_dot_v (
        .i_clk (i_clk),
        .i_en  (w_en[5:3]),
        .i_a   (w_q),
        .i_b   (w_dir),
        .o_dot (w_v)
    );

    // Stage 7: signs of u, v and det - u, and the sum u + v.
    always_comb begin
        n_det_k = rth_pkg::t_cmp'(w_det);
        n_u_k   = rth_pkg::t_cmp'(w_u);
        n_v_k   = rth_pkg::t_cmp'(w_v);
        n_du    = n_det_k - n_u_k;
        n_w     = n_u_k + n_v_k;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_det_k    <= n_det_k;
            r_w        <= n_w;
            r_det_neg  <= n_det_k[KW-1];
            r_det_zero <= (n_det_k == '0);
            r_u_ge     <= !n_u_k[KW-1];
            r_u_le     <= n_u_k[KW-1] || (n_u_k == '0);
            r_v_ge     <= !n_v_k[KW-1];
            r_v_le     <= n_v_k[KW-1] || (n_v_k == '0);
            r_du_ge    <= !n_du[KW-1];
            r_du_le    <= n_du[KW-1] || (n_du == '0);
        end
    end

    // Stage 8: det - (u + v), then the comparisons mirrored by the sign of det.
    always_comb begin
        n_dw    = r_det_k - r_w;
        w_dw_ge = !n_dw[KW-1];
        w_dw_le = n_dw[KW-1] || (n_dw == '0);
        if (r_det_zero) begin
            n_hit = 1'b0;
        end else if (r_det_neg) begin
            n_hit = r_u_le && r_du_le && r_v_le && w_dw_le;
        end else begin
            n_hit = r_u_ge && r_du_ge && r_v_ge && w_dw_ge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_hit <= n_hit;
        end
    end

    assign o_hit = r_hit;

endmodule
